>>> design/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge and disabled while reset is active.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_AT(lbl, clk, rstn, !(cond), msg)

`endif

>>> design/fam_pkg.sv
// Shared types and constants of the multi-match key search block.
`default_nettype none

package fam_pkg;

  // Default number of keys the list can hold.
  localparam int unsigned LIST_DEPTH_DEF = 64;

  localparam int unsigned KEY_W      = 31;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 8;

  // Position reported when no stored key matches the query.
  localparam logic [POS_W-1:0] POS_NONE = 7'h7F;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } fam_func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // empty the list
    logic append;  // store the incoming key at the end of the list
    logic query;   // latch the query key and rewind the scan
    logic scan;    // a query scan is in progress
    logic finish;  // emit the final result of the run
  } fam_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drained;   // every stored key has been compared
    logic out_free;  // the output register can take a result this cycle
  } fam_sts_t;

endpackage

`default_nettype wire

>>> design/fam_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module fam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/fam_ctrl.sv
// Controller state machine: accepts items and sequences the query scan.
`default_nettype none

module fam_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire fam_pkg::fam_func_e  func_i,
  input  wire fam_pkg::fam_sts_t   sts_i,
  output fam_pkg::fam_cmd_t        cmd_o
);

  import fam_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == ST_IDLE);
    accept     = in_valid_i && in_ready_o;

    if (accept) begin
      unique case (func_i)
        FUNC_CLEAR:  cmd_o.clear  = 1'b1;
        FUNC_APPEND: cmd_o.append = 1'b1;
        FUNC_QUERY: begin
          cmd_o.query = 1'b1;
          state_d     = ST_SCAN;
        end
        default: ;
      endcase
    end

    if (state_q == ST_SCAN) begin
      cmd_o.scan = 1'b1;
      if (sts_i.drained && sts_i.out_free) begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/fam_dp.sv
// Datapath: key memory, entry count, compare stage, pending match and output register.
`default_nettype none

module fam_dp #(
  parameter int unsigned ListDepth = fam_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fam_pkg::fam_cmd_t          cmd_i,
  output fam_pkg::fam_sts_t               sts_o,
  input  wire logic [fam_pkg::KEY_W-1:0]  key_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [fam_pkg::POS_W-1:0]  out_pos_o,
  output logic                            out_found_o,
  output logic                            out_last_o
);

  import fam_pkg::*;

  localparam int unsigned CntW  = $clog2(ListDepth + 1);
  localparam int unsigned AddrW = (ListDepth > 1) ? $clog2(ListDepth) : 1;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0] cmp_idx_q, cmp_idx_d;
  logic             pend_vld_q, pend_vld_d;
  logic [AddrW-1:0] pend_idx_q, pend_idx_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             out_vld_q, out_vld_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic             out_found_q, out_found_d;
  logic             out_last_q, out_last_d;

  logic             list_full;
  logic             rd_more;
  logic             match;
  logic             out_free;
  logic             adv;
  logic             ram_we;
  logic             ram_re;
  logic [KEY_W-1:0] ram_rdata;

  assign list_full = (count_q == CntW'(ListDepth));
  assign rd_more   = (rd_idx_q != count_q);
  assign out_free  = !out_vld_q || out_ready_i;
  // A match only stalls the scan when it must push an older pending match out.
  assign match     = cmp_vld_q && (ram_rdata == key_q);
  assign adv       = cmd_i.scan && (out_free || !(match && pend_vld_q));
  assign ram_we    = cmd_i.append && !list_full;
  assign ram_re    = adv && rd_more;

  fam_ram #(
    .Width (KEY_W),
    .Depth (ListDepth)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (key_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    key_d       = key_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_pos_d   = out_pos_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;

    if (cmd_i.clear) begin
      count_d = '0;
    end
    if (ram_we) begin
      count_d = count_q + CntW'(1);
    end

    if (cmd_i.query) begin
      key_d      = key_i;
      rd_idx_d   = '0;
      cmp_vld_d  = 1'b0;
      pend_vld_d = 1'b0;
    end

    if (adv) begin
      cmp_vld_d = rd_more;
      if (rd_more) begin
        cmp_idx_d = rd_idx_q[AddrW-1:0];
        rd_idx_d  = rd_idx_q + CntW'(1);
      end
      if (match) begin
        // The older match is known not to be last, so it leaves now.
        if (pend_vld_q) begin
          out_vld_d   = 1'b1;
          out_pos_d   = POS_W'(pend_idx_q);
          out_found_d = 1'b1;
          out_last_d  = 1'b0;
        end
        pend_vld_d = 1'b1;
        pend_idx_d = cmp_idx_q;
      end
    end

    if (cmd_i.finish) begin
      out_vld_d  = 1'b1;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
      if (pend_vld_q) begin
        out_pos_d   = POS_W'(pend_idx_q);
        out_found_d = 1'b1;
      end else begin
        out_pos_d   = POS_NONE;
        out_found_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    pend_idx_q  <= pend_idx_d;
    key_q       <= key_d;
    out_pos_q   <= out_pos_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
  end

  assign sts_o.drained  = !rd_more && !cmp_vld_q;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_vld_q;
  assign out_pos_o   = out_pos_q;
  assign out_found_o = out_found_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> design/find_all_match_positions.sv
// Top level of the multi-match key search: stream ports, controller and datapath.
`default_nettype none

// The block keeps a list of up to LIST_DEPTH keys of 31 bits in a single memory.
// Each input transfer carries an operation in tuser and a key in tdata: a clear empties
// the list, an append stores the key at the end of the list (ignored when the list is
// full), and a query reports, in ascending order, every 0-based list position whose key
// equals the query key. A query with no match, including one on an empty list, gives a
// single result with position -1 and found low. The last result of each query has tlast
// set. Clear, append and the unused operation code give no result and do not hold off
// the input, so they can follow each other with no gap. A query holds off the input
// until its scan has compared every stored key and its final result is taken into the
// output register, and longer while the output side stalls. The key memory has one
// read port with a registered read and the datapath compares one stored key per cycle
// unless the scan stalls, so each key is read, then compared, and last comes the
// final result. A one-entry output register and a one-entry pending-match register stand
// between the scan and the output, so a result may wait there while the block already
// takes the next transfer once the scan is over.

module find_all_match_positions #(
  parameter int unsigned LIST_DEPTH = fam_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Bits from the lowest up: key [30:0], zero padding [31].
  input  wire logic [fam_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // Bits from the lowest up: func [1:0].
  input  wire logic [fam_pkg::FUNC_W-1:0]      s_axis_tuser,

  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Bits from the lowest up: position [6:0] (two's complement), zero padding [7].
  output logic      [fam_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // Bits from the lowest up: found [0].
  output logic      [0:0]                      m_axis_tuser,
  // High on the last result of a query.
  output logic                                 m_axis_tlast
);

  import fam_pkg::*;

  fam_cmd_t         cmd;
  fam_sts_t         sts;
  logic [POS_W-1:0] out_pos;

  // The controller decodes the operation and runs the query scan sequence.
  fam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (fam_func_e'(s_axis_tuser)),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the key memory, the entry count and the result registers.
  fam_dp #(
    .ListDepth (LIST_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .key_i       (s_axis_tdata[KEY_W-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pos_o   (out_pos),
    .out_found_o (m_axis_tuser[0]),
    .out_last_o  (m_axis_tlast)
  );

  // The position sits in the low bits of tdata and the byte is filled up with zeros.
  assign m_axis_tdata = {{(M_TDATA_W - POS_W){1'b0}}, out_pos};

endmodule

`default_nettype wire

>>> design/fam_checker.sv
// Port-level checker for the multi-match key search, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module fam_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [fam_pkg::FUNC_W-1:0]     s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [fam_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic [0:0]                     m_axis_tuser,
  input wire logic                           m_axis_tlast
);

  import fam_pkg::*;

  // A stalled result holds its value until it is taken.
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // A result without a match is the single -1 result that closes its query.
  `ASSERT_NEVER(a_none_form, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] && !(m_axis_tlast && (m_axis_tdata == {1'b0, POS_NONE})), "no-match result is malformed")

  // A real match lies inside the list, so its position is never negative.
  `ASSERT_NEVER(a_found_range, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] && (m_axis_tdata[M_TDATA_W-1:POS_W-1] != '0), "match position out of range")

  // A query transfer starts a scan, so no transfer is taken in the next cycle.
  `ASSERT_AT(a_query_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_QUERY) |=> !s_axis_tready, "input ready during a query scan")

endmodule

bind find_all_match_positions fam_checker u_fam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
